// ===== rtl/pad_pkg.sv =====
// Package for the phase-angle dimmer: widths, codes, reset values and divider constants.
package pad_pkg;

	localparam int OP_W       = 2;
	localparam int PCT_W      = 7;
	localparam int LEVEL_W    = 8;
	localparam int DELAY_W    = 14;
	localparam int PULSE_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int PROD_W     = LEVEL_W + DELAY_W;

	typedef enum logic [OP_W-1:0] {
		OP_US_TICK    = 2'd0,
		OP_ZERO_CROSS = 2'd1,
		OP_RAMP_TICK  = 2'd2,
		OP_SET_TARGET = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RAMP_STEP     = 3'd0,
		REG_MAX_DELAY     = 3'd1,
		REG_MIN_DELAY     = 3'd2,
		REG_FULL_ON_DELAY = 3'd3,
		REG_SHORT_PULSE   = 3'd4,
		REG_LONG_PULSE    = 3'd5
	} cfg_reg_t;

	localparam logic [LEVEL_W-1:0] FULL_ON_LEVEL = 8'd196;
	localparam logic [PCT_W-1:0]   PCT_MAX       = 7'd100;
	localparam logic [DELAY_W-1:0] ELAPSED_MAX   = 14'd16383;

	// floor(p/196) = floor((p>>2)/49); /49 by reciprocal, exact for p >> 2 below 2^20
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP_W     = 21;
	localparam logic [RECIP_W-1:0] RECIP_49 = 21'd1369569;

	localparam logic [LEVEL_W-1:0] RST_RAMP_STEP     = 8'd1;
	localparam logic [DELAY_W-1:0] RST_MAX_DELAY     = 14'd8500;
	localparam logic [DELAY_W-1:0] RST_MIN_DELAY     = 14'd250;
	localparam logic [DELAY_W-1:0] RST_FULL_ON_DELAY = 14'd100;
	localparam logic [PULSE_W-1:0] RST_SHORT_PULSE   = 10'd50;
	localparam logic [PULSE_W-1:0] RST_LONG_PULSE    = 10'd300;

endpackage

// ===== rtl/pad_if.sv =====
// Stream interfaces for dimmer command beats and result beats.
interface pad_cmd_if;
	import pad_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [PCT_W-1:0] target_percent;

	modport source (output valid, output operation, output target_percent, input ready);
	modport sink (input valid, input operation, input target_percent, output ready);
endinterface

interface pad_res_if;
	import pad_pkg::*;

	logic               valid;
	logic               ready;
	logic               gate;
	logic [LEVEL_W-1:0] level_half_percent;
	logic [DELAY_W-1:0] phase_delay_us;
	logic               full_on;

	modport source (output valid, output gate, output level_half_percent,
		output phase_delay_us, output full_on, input ready);
	modport sink (input valid, input gate, input level_half_percent,
		input phase_delay_us, input full_on, output ready);
endinterface

// ===== rtl/phase_angle_dimmer_core.sv =====
// Phase-angle TRIAC dimmer core: ramped level, delay mapping and gate timing.
//
//  channel | dir | beat contents                                  | handshake
//  --------+-----+------------------------------------------------+-------------
//  cmd     | in  | operation, target_percent                      | valid/ready
//  res     | out | gate, level_half_percent, phase_delay_us, full | valid/ready
//  cfg_*   | in  | cfg_we, cfg_index, cfg_data                    | write enable
//
// One command beat is taken per clock while the pipe is not stalled; its single
// result beat passes four register stages, the first loaded on the accepting edge.
// Stage 1 sets the target and ramps the level, stage 2 multiplies level by the delay
// span, stage 3 divides by 196 (reciprocal multiply) and forms the delay, stage 4
// runs the crossing/countdown/pulse state and holds the result beat.
// The whole pipe stalls together while a result beat waits on res.ready.
// arst_n clears the valid bits, level, target and gate timing state and loads the register reset values.
module phase_angle_dimmer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	pad_cmd_if.sink                         cmd,
	pad_res_if.source                       res,
	input  logic                            cfg_we,
	input  logic [pad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pad_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pad_pkg::*;

	// configuration registers
	logic [LEVEL_W-1:0] ramp_step_q;
	logic [DELAY_W-1:0] max_delay_q, min_delay_q, full_on_delay_q;
	logic [PULSE_W-1:0] short_pulse_q, long_pulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q     <= RST_RAMP_STEP;
			max_delay_q     <= RST_MAX_DELAY;
			min_delay_q     <= RST_MIN_DELAY;
			full_on_delay_q <= RST_FULL_ON_DELAY;
			short_pulse_q   <= RST_SHORT_PULSE;
			long_pulse_q    <= RST_LONG_PULSE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RAMP_STEP:     ramp_step_q     <= cfg_data[LEVEL_W-1:0];
				REG_MAX_DELAY:     max_delay_q     <= cfg_data[DELAY_W-1:0];
				REG_MIN_DELAY:     min_delay_q     <= cfg_data[DELAY_W-1:0];
				REG_FULL_ON_DELAY: full_on_delay_q <= cfg_data[DELAY_W-1:0];
				REG_SHORT_PULSE:   short_pulse_q   <= cfg_data[PULSE_W-1:0];
				REG_LONG_PULSE:    long_pulse_q    <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipe control: everything advances together unless the result is held
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en, take;

	assign en        = !out_valid_q || res.ready;
	assign cmd.ready = en;
	assign take      = cmd.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= cmd.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// stage 1: target and ramped level (state loop closes here)
	logic [LEVEL_W-1:0] level_q, target_q, level_d, target_d;
	logic [LEVEL_W-1:0] diff_c;
	logic [PCT_W-1:0]   pct_c;
	op_t                op_c;

	assign op_c = op_t'(cmd.operation);

	always_comb begin
		level_d  = level_q;
		target_d = target_q;
		pct_c    = (cmd.target_percent > PCT_MAX) ? PCT_MAX : cmd.target_percent;
		diff_c   = (target_q > level_q) ? (target_q - level_q) : (level_q - target_q);
		case (op_c)
			OP_SET_TARGET: target_d = {pct_c, 1'b0};
			OP_RAMP_TICK: begin
				if (level_q != target_q) begin
					if (ramp_step_q == '0 || diff_c <= ramp_step_q)
						level_d = target_q;
					else if (target_q > level_q)
						level_d = level_q + ramp_step_q;
					else
						level_d = level_q - ramp_step_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			target_q <= '0;
		end else if (take) begin
			level_q  <= level_d;
			target_q <= target_d;
		end
	end

	op_t                op_s1, op_s2, op_s3;
	logic [LEVEL_W-1:0] level_s1, level_s2, level_s3;
	logic               full_s1, full_s2, full_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= op_c;
			level_s1 <= level_d;
			full_s1  <= (level_d >= FULL_ON_LEVEL);
		end
	end

	// stage 2: level times span; a reversed range gives span 0
	logic [DELAY_W-1:0] span_c;
	logic [PROD_W-1:0]  prod_s2;

	assign span_c = (max_delay_q >= min_delay_q) ? (max_delay_q - min_delay_q) : '0;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2    <= op_s1;
			level_s2 <= level_s1;
			full_s2  <= full_s1;
			prod_s2  <= PROD_W'(level_s1) * PROD_W'(span_c);
		end
	end

	// stage 3: divide by 196 and form the delay
	localparam int RP_W = PROD_W - 2 + RECIP_W;
	logic [RP_W-1:0]    recip_c;
	logic [DELAY_W-1:0] quot_c;
	logic [DELAY_W-1:0] delay_s3;

	assign recip_c = RP_W'(prod_s2[PROD_W-1:2]) * RP_W'(RECIP_49);
	assign quot_c  = recip_c[RECIP_SHIFT +: DELAY_W];

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3    <= op_s2;
			level_s3 <= level_s2;
			full_s3  <= full_s2;
			delay_s3 <= full_s2 ? full_on_delay_q : (max_delay_q - quot_c);
		end
	end

	// stage 4: crossing latch, microsecond countdown and gate pulse
	logic               armed_q, armed_d;
	logic [DELAY_W-1:0] elapsed_q, elapsed_d, latched_delay_q, latched_delay_d;
	logic [PULSE_W-1:0] pulse_left_q, pulse_left_d;

	always_comb begin
		armed_d         = armed_q;
		elapsed_d       = elapsed_q;
		latched_delay_d = latched_delay_q;
		pulse_left_d    = pulse_left_q;
		if (v_s3) begin
			case (op_s3)
				OP_ZERO_CROSS: begin
					latched_delay_d = delay_s3;
					elapsed_d       = '0;
					armed_d         = 1'b1;
				end
				OP_US_TICK: begin
					if (pulse_left_q != '0)
						pulse_left_d = pulse_left_q - 1'b1;
					if (armed_q) begin
						if (elapsed_q < ELAPSED_MAX)
							elapsed_d = elapsed_q + 1'b1;
						// firing tick; a running pulse is retriggered
						if (elapsed_d >= latched_delay_q) begin
							armed_d      = 1'b0;
							pulse_left_d = full_s3 ? long_pulse_q : short_pulse_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q         <= 1'b0;
			elapsed_q       <= '0;
			latched_delay_q <= '0;
			pulse_left_q    <= '0;
		end else if (en) begin
			armed_q         <= armed_d;
			elapsed_q       <= elapsed_d;
			latched_delay_q <= latched_delay_d;
			pulse_left_q    <= pulse_left_d;
		end
	end

	// result beat register
	logic               gate_q, full_on_q;
	logic [LEVEL_W-1:0] res_level_q;
	logic [DELAY_W-1:0] res_delay_q;

	always_ff @(posedge clk) begin
		if (en) begin
			gate_q      <= (pulse_left_d != '0);
			res_level_q <= level_s3;
			res_delay_q <= delay_s3;
			full_on_q   <= full_s3;
		end
	end

	assign res.valid              = out_valid_q;
	assign res.gate               = gate_q;
	assign res.level_half_percent = res_level_q;
	assign res.phase_delay_us     = res_delay_q;
	assign res.full_on            = full_on_q;

endmodule
